/* rtl/core/jspp_pkg.sv */
// shared constants, codes and types of the job scheduler policy picker
// no dependencies; imported by every module of the block
`default_nettype none

package jspp_pkg;

    // slot table size and derived widths
    localparam int MAX_JOBS = 64;
    localparam int SLOT_W   = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    // field widths
    localparam int REM_W    = 24;
    localparam int TIME_W   = 32;
    localparam int POL_W    = 2;
    localparam int QUANT_W  = 16;
    localparam int CHUNK_W  = 16;
    localparam int JOBS_W   = 7;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;

    // scheduling policies
    localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
    localparam logic [POL_W-1:0] POL_RR   = 2'd1;
    localparam logic [POL_W-1:0] POL_SJF  = 2'd2;
    localparam logic [POL_W-1:0] POL_PSJF = 2'd3;

    // request opcodes
    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // register indexes
    localparam logic [1:0] REG_POLICY  = 2'd0;
    localparam logic [1:0] REG_QUANTUM = 2'd1;
    localparam logic [1:0] REG_CHUNK   = 2'd2;
    localparam logic [1:0] REG_JOBS    = 2'd3;

    // register reset values
    localparam logic [POL_W-1:0]   RST_POLICY  = POL_FIFO;
    localparam logic [QUANT_W-1:0] RST_QUANTUM = 16'd500;
    localparam logic [CHUNK_W-1:0] RST_CHUNK   = 16'd100;
    localparam logic [JOBS_W-1:0]  RST_JOBS    = JOBS_W'(MAX_JOBS);

    // configuration register contents
    typedef struct packed {
        logic [POL_W-1:0]   policy;
        logic [QUANT_W-1:0] quantum;
        logic [CHUNK_W-1:0] run_chunk;
        logic [JOBS_W-1:0]  job_count;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic admit;
        logic rd_run;
        logic retire;
        logic mod_q_start;
        logic mod_n_start;
        logic scan_init;
        logic scan_init_rr;
        logic scan_step;
        logic take_hit;
        logic sjf_issue;
        logic do_switch;
        logic run;
        logic load_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic             op;
        logic [POL_W-1:0] policy;
        logic             run_valid;
        logic             hit;
        logic             last;
        logic             mod_done;
        logic             mod_zero;
        logic             out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/core/job_scheduler_policy_picker.sv */
// top level of the job scheduler policy picker: register port and core wiring
// depends on jspp_pkg, jspp_ctrl and jspp_datapath
`default_nettype none

// Job scheduler policy picker. Requests are taken one at a time. An admit
// request is dispatched, writes its burst to the remaining-time memory and
// then loads the output register once it is free. A step request is
// dispatched, reads the running job, retires it if it is finished, searches
// as its policy needs, switches, runs one chunk and then loads the output
// register once it is free. A running FIFO or non-preemptive shortest job
// needs no search. FIFO and the first pick of round robin walk the active
// marks one slot per cycle, then make the switch. Shortest job first reads
// the remaining-time memory through its single read port, one slot per
// cycle, then makes the switch. A running round robin job passes through the
// iterative remainder unit for the slice check; at a slice boundary it passes
// through it again for the rotation start, then walks the active marks and
// makes the switch. A new request is taken while the previous result is
// still waiting in the output register. There is no clearing pass after
// reset.
module job_scheduler_policy_picker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_opcode,
    input  wire logic [jspp_pkg::SLOT_W-1:0]   i_slot,
    input  wire logic [jspp_pkg::REM_W-1:0]    i_burst,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [jspp_pkg::SLOT_W-1:0]        o_chosen_slot,
    output logic                               o_chosen_valid,
    output logic [jspp_pkg::SLOT_W-1:0]        o_retired_slot,
    output logic                               o_retired_valid,
    output logic [jspp_pkg::TIME_W-1:0]        o_now_time,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [jspp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [jspp_pkg::DATA_W-1:0]   pwdata,
    output logic [jspp_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import jspp_pkg::*;

    t_cfg       r_cfg;
    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [1:0] n_reg_idx;
    logic       n_wr;

    assign n_reg_idx = paddr[3:2];
    assign n_wr      = psel && penable && pwrite;
    assign pready    = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy    <= RST_POLICY;
            r_cfg.quantum   <= RST_QUANTUM;
            r_cfg.run_chunk <= RST_CHUNK;
            r_cfg.job_count <= RST_JOBS;
        end else if (n_wr) begin
            unique case (n_reg_idx)
                REG_POLICY:  r_cfg.policy    <= pwdata[POL_W-1:0];
                REG_QUANTUM: r_cfg.quantum   <= pwdata[QUANT_W-1:0];
                REG_CHUNK:   r_cfg.run_chunk <= pwdata[CHUNK_W-1:0];
                REG_JOBS:    r_cfg.job_count <= pwdata[JOBS_W-1:0];
                default:     r_cfg           <= r_cfg;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (n_reg_idx)
            REG_POLICY:  prdata = DATA_W'(r_cfg.policy);
            REG_QUANTUM: prdata = DATA_W'(r_cfg.quantum);
            REG_CHUNK:   prdata = DATA_W'(r_cfg.run_chunk);
            REG_JOBS:    prdata = DATA_W'(r_cfg.job_count);
            default:     prdata = '0;
        endcase
    end

    jspp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    jspp_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_opcode        (i_opcode),
        .i_slot          (i_slot),
        .i_burst         (i_burst),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_chosen_slot   (o_chosen_slot),
        .o_chosen_valid  (o_chosen_valid),
        .o_retired_slot  (o_retired_slot),
        .o_retired_valid (o_retired_valid),
        .o_now_time      (o_now_time)
    );

endmodule

`default_nettype wire

/* rtl/core/jspp_mod_unit.sv */
// iterative remainder unit, one quotient bit per cycle (restoring)
// depends on jspp_pkg for widths
`default_nettype none

module jspp_mod_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [jspp_pkg::TIME_W-1:0]   i_dividend,
    input  wire logic [jspp_pkg::QUANT_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic [jspp_pkg::QUANT_W-1:0]       o_rem
);
    import jspp_pkg::*;

    localparam int STEP_W = $clog2(TIME_W);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [TIME_W-1:0]   r_dvd;
    logic [QUANT_W-1:0]  r_dsr;
    logic [QUANT_W-1:0]  r_part;
    logic [QUANT_W:0]    n_trial;
    logic [QUANT_W:0]    n_diff;

    // shift in next dividend bit and try a subtract
    always_comb begin
        n_trial = {r_part, r_dvd[TIME_W-1]};
        n_diff  = n_trial - {1'b0, r_dsr};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_dsr  <= i_divisor;
            r_part <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            if (n_trial >= {1'b0, r_dsr}) begin
                r_part <= n_diff[QUANT_W-1:0];
            end else begin
                r_part <= n_trial[QUANT_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_part;

endmodule

`default_nettype wire

/* rtl/core/jspp_datapath.sv */
// slot table, remaining-time memory, scan logic, time keeping and result register
// depends on jspp_pkg and jspp_mod_unit; driven by jspp_ctrl commands
`default_nettype none

module jspp_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire jspp_pkg::t_cfg                i_cfg,
    input  wire jspp_pkg::t_cmd                i_cmd,
    output jspp_pkg::t_sts                     o_sts,
    input  wire logic                          i_opcode,
    input  wire logic [jspp_pkg::SLOT_W-1:0]   i_slot,
    input  wire logic [jspp_pkg::REM_W-1:0]    i_burst,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [jspp_pkg::SLOT_W-1:0]        o_chosen_slot,
    output logic                               o_chosen_valid,
    output logic [jspp_pkg::SLOT_W-1:0]        o_retired_slot,
    output logic                               o_retired_valid,
    output logic [jspp_pkg::TIME_W-1:0]        o_now_time
);
    import jspp_pkg::*;

    // request fields
    logic                r_op;
    logic [SLOT_W-1:0]   r_slot;
    logic [REM_W-1:0]    r_burst;

    // scheduler state
    logic [MAX_JOBS-1:0] r_active;
    logic [SLOT_W-1:0]   r_run_idx;
    logic                r_run_v;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_last;

    // remaining-time memory
    logic [REM_W-1:0]    r_rem_mem [MAX_JOBS];
    logic [REM_W-1:0]    r_rd_data;
    logic [SLOT_W-1:0]   n_rd_addr;
    logic                n_we;
    logic [SLOT_W-1:0]   n_wr_addr;
    logic [REM_W-1:0]    n_wr_data;

    // scan state
    logic [SLOT_W-1:0]   r_idx;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_pick_v;
    logic [SLOT_W-1:0]   r_pick_idx;
    logic [REM_W-1:0]    r_pick_rem;
    logic                r_cmp_v;
    logic                r_cmp_act;
    logic [SLOT_W-1:0]   r_cmp_idx;
    logic [SLOT_W-1:0]   n_idx_next;

    // step results
    logic                r_ch_v;
    logic [SLOT_W-1:0]   r_ch_idx;
    logic                r_ret_v;
    logic [SLOT_W-1:0]   r_ret_idx;

    // output register
    logic                r_o_valid;
    logic [SLOT_W-1:0]   r_o_ch_idx;
    logic                r_o_ch_v;
    logic [SLOT_W-1:0]   r_o_ret_idx;
    logic                r_o_ret_v;
    logic [TIME_W-1:0]   r_o_now;

    // effective register values
    logic [CNT_W-1:0]    n_jobs;
    logic [QUANT_W-1:0]  n_quant;
    logic [REM_W-1:0]    n_chunk;
    logic                n_rem_gt;

    // remainder unit
    logic                n_mod_start;
    logic [TIME_W-1:0]   n_mod_dvd;
    logic [QUANT_W-1:0]  n_mod_dsr;
    logic                w_mod_done;
    logic [QUANT_W-1:0]  w_mod_rem;

    // clamp registers to their usable ranges
    always_comb begin
        if (i_cfg.job_count == '0) begin
            n_jobs = CNT_W'(1);
        end else if (CNT_W'(i_cfg.job_count) > CNT_W'(MAX_JOBS)) begin
            n_jobs = CNT_W'(MAX_JOBS);
        end else begin
            n_jobs = CNT_W'(i_cfg.job_count);
        end
        n_quant = (i_cfg.quantum == '0) ? QUANT_W'(1) : i_cfg.quantum;
        n_chunk = (i_cfg.run_chunk == '0) ? REM_W'(1) : REM_W'(i_cfg.run_chunk);
        n_rem_gt = r_rd_data > n_chunk;
    end

    // scan index advances modulo the slot count
    always_comb begin
        if ((CNT_W'(r_idx) + CNT_W'(1)) == n_jobs) begin
            n_idx_next = '0;
        end else begin
            n_idx_next = r_idx + 1'b1;
        end
    end

    // remainder requests: elapsed time by quantum, or rotation start by slot count
    always_comb begin
        n_mod_start = i_cmd.mod_q_start | i_cmd.mod_n_start;
        if (i_cmd.mod_n_start) begin
            n_mod_dvd = TIME_W'(r_run_idx) + TIME_W'(1);
            n_mod_dsr = QUANT_W'(n_jobs);
        end else begin
            n_mod_dvd = r_now - r_last;
            n_mod_dsr = n_quant;
        end
    end

    jspp_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_mod_start),
        .i_dividend (n_mod_dvd),
        .i_divisor  (n_mod_dsr),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // memory port selection
    always_comb begin
        n_rd_addr = i_cmd.rd_run ? r_run_idx : r_idx;
        n_we      = 1'b0;
        n_wr_addr = r_run_idx;
        n_wr_data = '0;
        if (i_cmd.admit) begin
            n_we      = 1'b1;
            n_wr_addr = r_slot;
            n_wr_data = r_burst;
        end else if (i_cmd.run && r_run_v) begin
            n_we      = 1'b1;
            n_wr_data = n_rem_gt ? (r_rd_data - n_chunk) : '0;
        end
    end

    // remaining-time memory, registered read
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_rem_mem[n_wr_addr] <= n_wr_data;
        end
        r_rd_data <= r_rem_mem[n_rd_addr];
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_opcode;
            r_slot  <= i_slot;
            r_burst <= i_burst;
        end
    end

    // scheduler control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_run_idx <= '0;
            r_run_v   <= 1'b0;
            r_now     <= '0;
            r_last    <= '0;
            r_ch_v    <= 1'b0;
            r_ret_v   <= 1'b0;
            r_pick_v  <= 1'b0;
            r_cmp_v   <= 1'b0;
            r_idx     <= '0;
            r_cnt     <= '0;
        end else begin
            r_cmp_v <= i_cmd.sjf_issue;

            if (i_cmd.accept) begin
                r_ch_v  <= 1'b0;
                r_ret_v <= 1'b0;
            end

            if (i_cmd.admit) begin
                r_active[r_slot] <= 1'b1;
            end

            // retire a finished running job
            if (i_cmd.retire && r_run_v && r_rd_data == '0) begin
                r_active[r_run_idx] <= 1'b0;
                r_ret_v   <= 1'b1;
                r_run_v   <= 1'b0;
                r_run_idx <= '0;
            end

            // scan start and advance
            if (i_cmd.scan_init) begin
                r_idx    <= '0;
                r_cnt    <= '0;
                r_pick_v <= 1'b0;
            end else if (i_cmd.scan_init_rr) begin
                r_idx    <= w_mod_rem[SLOT_W-1:0];
                r_cnt    <= '0;
                r_pick_v <= 1'b0;
            end else if (i_cmd.scan_step || i_cmd.sjf_issue) begin
                r_idx <= n_idx_next;
                r_cnt <= r_cnt + 1'b1;
            end

            if (i_cmd.take_hit) begin
                r_pick_v <= 1'b1;
            end

            // shortest remaining time, ties to the lowest slot
            if (r_cmp_v && r_cmp_act && (!r_pick_v || r_rd_data < r_pick_rem)) begin
                r_pick_v <= 1'b1;
            end

            // switch to the picked job
            if (i_cmd.do_switch && r_pick_v && (!r_run_v || r_pick_idx != r_run_idx)) begin
                r_run_idx <= r_pick_idx;
                r_run_v   <= 1'b1;
                r_last    <= r_now;
            end

            // run for one chunk or idle one unit
            if (i_cmd.run) begin
                if (r_run_v) begin
                    r_now  <= r_now + (n_rem_gt ? TIME_W'(n_chunk) : TIME_W'(r_rd_data));
                    r_ch_v <= 1'b1;
                end else begin
                    r_now <= r_now + TIME_W'(1);
                end
            end
        end
    end

    // scan payload and step result slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.sjf_issue) begin
            r_cmp_idx <= r_idx;
            r_cmp_act <= r_active[r_idx];
        end
        if (i_cmd.take_hit) begin
            r_pick_idx <= r_idx;
        end
        if (r_cmp_v && r_cmp_act && (!r_pick_v || r_rd_data < r_pick_rem)) begin
            r_pick_idx <= r_cmp_idx;
            r_pick_rem <= r_rd_data;
        end
        if (i_cmd.retire) begin
            r_ret_idx <= r_run_idx;
        end
        if (i_cmd.run) begin
            r_ch_idx <= r_run_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_ch_v    <= r_ch_v;
            r_o_ch_idx  <= r_ch_v ? r_ch_idx : '0;
            r_o_ret_v   <= r_ret_v;
            r_o_ret_idx <= r_ret_v ? r_ret_idx : '0;
            r_o_now     <= r_now;
        end
    end

    // status back to the controller
    always_comb begin
        o_sts.op        = r_op;
        o_sts.policy    = i_cfg.policy;
        o_sts.run_valid = r_run_v;
        o_sts.hit       = r_active[r_idx];
        o_sts.last      = (r_cnt == (n_jobs - CNT_W'(1)));
        o_sts.mod_done  = w_mod_done;
        o_sts.mod_zero  = (w_mod_rem == '0);
        o_sts.out_free  = !r_o_valid || !i_stall;
    end

    assign o_valid         = r_o_valid;
    assign o_chosen_slot   = r_o_ch_idx;
    assign o_chosen_valid  = r_o_ch_v;
    assign o_retired_slot  = r_o_ret_idx;
    assign o_retired_valid = r_o_ret_v;
    assign o_now_time      = r_o_now;

endmodule

`default_nettype wire

/* rtl/core/jspp_ctrl.sv */
// sequencing state machine of the scheduler, one request at a time
// depends on jspp_pkg; commands jspp_datapath
`default_nettype none

module jspp_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire jspp_pkg::t_sts  i_sts,
    output jspp_pkg::t_cmd       o_cmd
);
    import jspp_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISPATCH = 4'd1;
    localparam logic [3:0] ST_ADMIT    = 4'd2;
    localparam logic [3:0] ST_RD_RUN   = 4'd3;
    localparam logic [3:0] ST_RETIRE   = 4'd4;
    localparam logic [3:0] ST_DECIDE   = 4'd5;
    localparam logic [3:0] ST_MOD_Q    = 4'd6;
    localparam logic [3:0] ST_MOD_N    = 4'd7;
    localparam logic [3:0] ST_SCAN_ACT = 4'd8;
    localparam logic [3:0] ST_SCAN_SJF = 4'd9;
    localparam logic [3:0] ST_SJF_LAST = 4'd10;
    localparam logic [3:0] ST_SWITCH   = 4'd11;
    localparam logic [3:0] ST_RD_PICK  = 4'd12;
    localparam logic [3:0] ST_RUN      = 4'd13;
    localparam logic [3:0] ST_OUT      = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_state = (i_sts.op == OP_ADMIT) ? ST_ADMIT : ST_RD_RUN;
            end
            ST_ADMIT: begin
                o_cmd.admit = 1'b1;
                n_state     = ST_OUT;
            end
            ST_RD_RUN: begin
                o_cmd.rd_run = 1'b1;
                n_state      = ST_RETIRE;
            end
            ST_RETIRE: begin
                o_cmd.retire = 1'b1;
                n_state      = ST_DECIDE;
            end
            // pick the search that the policy needs
            ST_DECIDE: begin
                unique case (i_sts.policy)
                    POL_FIFO: begin
                        if (i_sts.run_valid) begin
                            n_state = ST_RD_PICK;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = ST_SCAN_ACT;
                        end
                    end
                    POL_RR: begin
                        if (i_sts.run_valid) begin
                            o_cmd.mod_q_start = 1'b1;
                            n_state           = ST_MOD_Q;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = ST_SCAN_ACT;
                        end
                    end
                    POL_SJF: begin
                        if (i_sts.run_valid) begin
                            n_state = ST_RD_PICK;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = ST_SCAN_SJF;
                        end
                    end
                    default: begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = ST_SCAN_SJF;
                    end
                endcase
            end
            // slice boundary check
            ST_MOD_Q: begin
                if (i_sts.mod_done) begin
                    if (i_sts.mod_zero) begin
                        o_cmd.mod_n_start = 1'b1;
                        n_state           = ST_MOD_N;
                    end else begin
                        n_state = ST_RD_PICK;
                    end
                end
            end
            // rotation start slot
            ST_MOD_N: begin
                if (i_sts.mod_done) begin
                    o_cmd.scan_init_rr = 1'b1;
                    n_state            = ST_SCAN_ACT;
                end
            end
            // first active slot from the scan start
            ST_SCAN_ACT: begin
                if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = ST_SWITCH;
                end else if (i_sts.last) begin
                    n_state = ST_SWITCH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            // shortest job scan, one memory read per cycle
            ST_SCAN_SJF: begin
                o_cmd.sjf_issue = 1'b1;
                if (i_sts.last) begin
                    n_state = ST_SJF_LAST;
                end
            end
            ST_SJF_LAST: begin
                n_state = ST_SWITCH;
            end
            ST_SWITCH: begin
                o_cmd.do_switch = 1'b1;
                n_state         = ST_RD_PICK;
            end
            ST_RD_PICK: begin
                o_cmd.rd_run = 1'b1;
                n_state      = ST_RUN;
            end
            ST_RUN: begin
                o_cmd.run = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

/* bench/job_pick_checker.sv */
// request/result checker for the job scheduler policy picker: predicts every result
// from observed requests and register writes; depends on jspp_pkg
module job_pick_checker
    import jspp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // request channel as seen at the block
    input  wire logic                i_req_valid,
    input  wire logic                i_req_stall,
    input  wire logic                i_opcode,
    input  wire logic [SLOT_W-1:0]   i_slot,
    input  wire logic [REM_W-1:0]    i_burst,
    // result channel as seen at the block
    input  wire logic                i_res_valid,
    input  wire logic                i_res_stall,
    input  wire logic [SLOT_W-1:0]   i_chosen_slot,
    input  wire logic                i_chosen_valid,
    input  wire logic [SLOT_W-1:0]   i_retired_slot,
    input  wire logic                i_retired_valid,
    input  wire logic [TIME_W-1:0]   i_now_time,
    // register port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic                pready,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    // to the top
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic [SLOT_W-1:0] chosen_slot;
        logic              chosen_valid;
        logic [SLOT_W-1:0] retired_slot;
        logic              retired_valid;
        logic [TIME_W-1:0] now_time;
    } sched_outcome_t;

    // shadow registers
    logic [POL_W-1:0]   cfg_policy;
    logic [QUANT_W-1:0] cfg_quantum;
    logic [CHUNK_W-1:0] cfg_chunk;
    logic [JOBS_W-1:0]  cfg_jobs;

    // shadow scheduler state
    logic [REM_W-1:0]    time_left [MAX_JOBS];
    logic [MAX_JOBS-1:0] live;
    logic [SLOT_W-1:0]   run_slot;
    logic                run_on;
    logic [TIME_W-1:0]   clock_now;
    logic [TIME_W-1:0]   switch_at;

    sched_outcome_t outcomes [$];
    sched_outcome_t oldest;

    // number of slots searched, clamped to the table
    function automatic int scan_limit();
        if (cfg_jobs == 0) return 1;
        if (cfg_jobs > MAX_JOBS) return MAX_JOBS;
        return int'(cfg_jobs);
    endfunction

    function automatic int lowest_live(input int n);
        for (int i = 0; i < n; i++)
            if (live[i]) return i;
        return -1;
    endfunction

    // ties go to the lowest slot
    function automatic int shortest_live(input int n);
        int best;
        best = -1;
        for (int i = 0; i < n; i++)
            if (live[i] && (best < 0 || time_left[i] < time_left[best])) best = i;
        return best;
    endfunction

    // slot to run under the current policy, -1 when nothing is active
    function automatic int select_job();
        int n;
        int c;
        logic [TIME_W-1:0] q;
        logic [TIME_W-1:0] elapsed;
        n = scan_limit();
        if (cfg_policy == POL_FIFO) begin
            if (run_on) return int'(run_slot);
            return lowest_live(n);
        end else if (cfg_policy == POL_RR) begin
            if (!run_on) return lowest_live(n);
            q = (cfg_quantum == 0) ? 32'd1 : 32'(cfg_quantum);
            elapsed = clock_now - switch_at;
            if ((elapsed % q) != 0) return int'(run_slot);
            // rotate from the running slot, which may sit beyond the count
            for (int i = 1; i <= n; i++) begin
                c = (int'(run_slot) + i) % n;
                if (live[c]) return c;
            end
            return int'(run_slot);
        end else if (cfg_policy == POL_SJF) begin
            if (run_on) return int'(run_slot);
            return shortest_live(n);
        end
        return shortest_live(n);
    endfunction

    // apply one request to the shadow state and queue its result
    task automatic predict_request(input logic op, input logic [SLOT_W-1:0] slot,
                                   input logic [REM_W-1:0] burst);
        sched_outcome_t r;
        int pick;
        logic [TIME_W-1:0] grant;
        r = '0;
        if (op == OP_ADMIT) begin
            time_left[slot] = burst;
            live[slot] = 1'b1;
        end else begin
            // retire a finished job first
            if (run_on && time_left[run_slot] == 0) begin
                live[run_slot] = 1'b0;
                r.retired_slot = run_slot;
                r.retired_valid = 1'b1;
                run_on = 1'b0;
                run_slot = '0;
            end
            pick = select_job();
            if (pick >= 0 && (!run_on || pick != int'(run_slot))) begin
                run_slot = SLOT_W'(pick);
                run_on = 1'b1;
                switch_at = clock_now;
            end
            // run for one chunk or idle one unit
            if (run_on) begin
                grant = (cfg_chunk == 0) ? 32'd1 : 32'(cfg_chunk);
                if (32'(time_left[run_slot]) > grant) begin
                    clock_now = clock_now + grant;
                    time_left[run_slot] = time_left[run_slot] - REM_W'(grant);
                end else begin
                    clock_now = clock_now + 32'(time_left[run_slot]);
                    time_left[run_slot] = '0;
                end
                r.chosen_slot = run_slot;
                r.chosen_valid = 1'b1;
            end else begin
                clock_now = clock_now + 32'd1;
            end
        end
        r.now_time = clock_now;
        outcomes.push_back(r);
    endtask

    task automatic note_mismatch(input string field, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        o_fail_count++;
    endtask

    // compare results, then track register writes and requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_policy = RST_POLICY;
            cfg_quantum = RST_QUANTUM;
            cfg_chunk = RST_CHUNK;
            cfg_jobs = RST_JOBS;
            for (int i = 0; i < MAX_JOBS; i++) time_left[i] = '0;
            live = '0;
            run_slot = '0;
            run_on = 1'b0;
            clock_now = '0;
            switch_at = '0;
            outcomes.delete();
            o_fail_count = 0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (outcomes.size() == 0) begin
                    $display("%0t: result with nothing expected, actual chosen %0d/%0b",
                             $time, i_chosen_slot, i_chosen_valid);
                    o_fail_count++;
                end else begin
                    oldest = outcomes.pop_front();
                    if (i_chosen_slot !== oldest.chosen_slot)
                        note_mismatch("chosen_slot", 32'(oldest.chosen_slot), 32'(i_chosen_slot));
                    if (i_chosen_valid !== oldest.chosen_valid)
                        note_mismatch("chosen_valid", 32'(oldest.chosen_valid),
                                      32'(i_chosen_valid));
                    if (i_retired_slot !== oldest.retired_slot)
                        note_mismatch("retired_slot", 32'(oldest.retired_slot),
                                      32'(i_retired_slot));
                    if (i_retired_valid !== oldest.retired_valid)
                        note_mismatch("retired_valid", 32'(oldest.retired_valid),
                                      32'(i_retired_valid));
                    if (i_now_time !== oldest.now_time)
                        note_mismatch("now_time", oldest.now_time, i_now_time);
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_POLICY:  cfg_policy = pwdata[POL_W-1:0];
                    REG_QUANTUM: cfg_quantum = pwdata[QUANT_W-1:0];
                    REG_CHUNK:   cfg_chunk = pwdata[CHUNK_W-1:0];
                    REG_JOBS:    cfg_jobs = pwdata[JOBS_W-1:0];
                    default: ;
                endcase
            end
            if (i_req_valid && !i_req_stall) predict_request(i_opcode, i_slot, i_burst);
        end
        o_pending = outcomes.size();
    end

endmodule

/* bench/testbench.sv */
// top of the job scheduler policy picker bench: clock, reset, request and register
// stimulus, result stall pattern and verdict; depends on jspp_pkg and job_pick_checker
module testbench;
    import jspp_pkg::*;

    localparam int PHASE_ITEMS = 115;
    localparam int HOLD_CYCLES = 400;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic                req_op;
    logic [SLOT_W-1:0]   req_slot;
    logic [REM_W-1:0]    req_burst;
    logic                res_valid;
    logic                res_stall;
    logic [SLOT_W-1:0]   chosen_slot;
    logic                chosen_valid;
    logic [SLOT_W-1:0]   retired_slot;
    logic                retired_valid;
    logic [TIME_W-1:0]   now_time;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;

    // stall pattern controls
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    job_scheduler_policy_picker uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (req_valid),
        .o_stall         (req_stall),
        .i_opcode        (req_op),
        .i_slot          (req_slot),
        .i_burst         (req_burst),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_chosen_slot   (chosen_slot),
        .o_chosen_valid  (chosen_valid),
        .o_retired_slot  (retired_slot),
        .o_retired_valid (retired_valid),
        .o_now_time      (now_time),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    job_pick_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_valid),
        .i_req_stall     (req_stall),
        .i_opcode        (req_op),
        .i_slot          (req_slot),
        .i_burst         (req_burst),
        .i_res_valid     (res_valid),
        .i_res_stall     (res_stall),
        .i_chosen_slot   (chosen_slot),
        .i_chosen_valid  (chosen_valid),
        .i_retired_slot  (retired_slot),
        .i_retired_valid (retired_valid),
        .i_now_time      (now_time),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #40000000;
        $display("job_scheduler_policy_picker verification failed");
        $finish;
    end

    // result side stall: random, calm, or one long hold-off
    initial begin
        res_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                res_stall = 1'b1;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                res_stall = 1'b1;
            end else begin
                res_stall = !calm && ($urandom_range(0, 99) < 27);
            end
        end
    end

    // one register write, setup then access phase; starts and ends at a falling edge
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        paddr = {idx, 2'b00};
        pwdata = value;
        pwrite = 1'b1;
        psel = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // offer one request, with a random gap in front, and wait for its acceptance
    task automatic send_request(input logic op, input logic [SLOT_W-1:0] slot,
                                input logic [REM_W-1:0] burst);
        int gap;
        if (!calm && $urandom_range(0, 99) < 27) begin
            req_valid = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        req_valid = 1'b1;
        req_op = op;
        req_slot = slot;
        req_burst = burst;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering until every expected result has come back
    task automatic wait_drained();
        req_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // one register setting followed by random requests
    task automatic run_phase(input logic [POL_W-1:0] pol, input logic [QUANT_W-1:0] slice,
                             input logic [CHUNK_W-1:0] chunk, input logic [JOBS_W-1:0] jobs);
        int span;
        int grant;
        int roll;
        logic [SLOT_W-1:0] slot;
        logic [REM_W-1:0] burst;
        write_reg(REG_POLICY, DATA_W'(pol));
        write_reg(REG_QUANTUM, DATA_W'(slice));
        write_reg(REG_CHUNK, DATA_W'(chunk));
        write_reg(REG_JOBS, DATA_W'(jobs));
        span = (jobs == 0) ? 1 : (jobs > MAX_JOBS) ? MAX_JOBS : int'(jobs);
        grant = (chunk == 0) ? 1 : int'(chunk);
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2) wait_drained();
            if ($urandom_range(0, 99) < 40) begin
                // admits mostly land inside the scanned range, bursts near the chunk size
                if ($urandom_range(0, 9) < 8) slot = SLOT_W'($urandom_range(0, span - 1));
                else slot = SLOT_W'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 8) burst = '0;
                else if (roll < 11) burst = REM_W'($urandom);
                else burst = REM_W'($urandom_range(1, 3 * grant));
                send_request(OP_ADMIT, slot, burst);
            end else begin
                send_request(OP_STEP, SLOT_W'($urandom), REM_W'($urandom));
            end
        end
        wait_drained();
    endtask

    // stimulus and verdict
    initial begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_op = OP_ADMIT;
        req_slot = '0;
        req_burst = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero burst run and retire, extremes, overwrite of a running job
        send_request(OP_ADMIT, 6'd0, 24'd0);
        send_request(OP_STEP, 6'd0, 24'd0);
        send_request(OP_STEP, 6'd63, 24'hFFFFFF);
        send_request(OP_ADMIT, 6'd63, 24'hFFFFFF);
        send_request(OP_ADMIT, 6'd42, 24'd1);
        send_request(OP_STEP, 6'd0, 24'd0);
        send_request(OP_ADMIT, 6'd42, 24'd300);
        send_request(OP_STEP, 6'd0, 24'd0);
        send_request(OP_STEP, 6'd0, 24'd0);
        send_request(OP_STEP, 6'd0, 24'd0);
        send_request(OP_STEP, 6'd0, 24'd0);
        send_request(OP_ADMIT, 6'd7, 24'd150);
        send_request(OP_ADMIT, 6'd1, 24'd40);
        send_request(OP_STEP, 6'd0, 24'd0);
        wait_drained();

        // slot 63 keeps running beyond a small count; zero slice and zero chunk
        run_phase(POL_RR, 16'd0, 16'd0, 7'd4);
        run_phase(POL_PSJF, 16'd500, 16'd100, 7'd127);
        // long result hold-off fills the block and stalls requests
        hold_req = 1'b1;
        run_phase(POL_FIFO, 16'd65535, 16'd65535, 7'd64);
        calm = 1'b1;
        run_phase(POL_SJF, 16'd1, 16'd65535, 7'd16);
        calm = 1'b0;
        run_phase(POL_RR, 16'd65535, 16'd1, 7'd64);
        run_phase(POL_RR, 16'd3, 16'd50, 7'd8);
        run_phase(POL_PSJF, 16'd1, 16'd1, 7'd0);
        run_phase(POL_SJF, 16'd700, 16'd200, 7'd64);
        run_phase(POL_FIFO, 16'd2, 16'd300, 7'd1);
        run_phase(POL_RR, 16'd1, 16'd65535, 7'd2);
        run_phase(RST_POLICY, RST_QUANTUM, RST_CHUNK, RST_JOBS);

        // let any stray result show up
        repeat (200) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("job_scheduler_policy_picker verification clean");
        end else begin
            $display("job_scheduler_policy_picker verification failed");
        end
        $finish;
    end

endmodule
